FILE: src/smq_pkg.sv
// ============================================================================
// smq_pkg: shared types and codes for the sorted message queue
// Entry and result layouts, command and status codes.
// ============================================================================
package smq_pkg;

  localparam int KEY_W = 32;
  localparam int TAG_W = 16;
  localparam int OCC_W = 5;
  localparam int STS_W = 2;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  // status codes
  localparam logic [STS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STS_W-1:0] ST_EMPTY = 2'd2;

  // one stored message entry
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] ends;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // one result transaction
  typedef struct packed {
    logic [STS_W-1:0] status;
    logic [KEY_W-1:0] start_date;
    logic [KEY_W-1:0] end_date;
    logic [TAG_W-1:0] tag;
    logic [OCC_W-1:0] occupancy;
  } result_t;

  // signed compare a < b on raw key bits
  function automatic logic key_less(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

FILE: src/sorted_message_queue.sv
// ============================================================================
// sorted_message_queue: date-ordered message queue
// Holds up to CAPACITY entries sorted by ascending signed start date in a
// circular buffer kept in one synchronous memory; pops the head entry.
// ============================================================================
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------------
//  in      | in_valid / in_stall | cmd, start_date, end_date, message_tag
//  out     | out_valid/out_stall | status, popped_start_date, popped_end_date,
//          |                     | popped_tag, occupancy
//
//  One transaction at a time. Pop accepts the command, then takes the head
//  entry from memory; a pop on an empty queue and an insert into a full or
//  empty queue finish on acceptance. Any other insert moves the entries above
//  the insert point up one slot, the single memory read port stepping from the
//  tail toward the insert point one entry a cycle, then writes the new entry.
//  A finished result loads the output register when it is free; if that
//  register still holds an unaccepted result, the new one parks and the input
//  stalls until the receiver takes the old one and the parked one moves over.
//  Reset (rst, synchronous): clears count, head pointer and control state;
//  the input stalls while reset is high. The memory is not cleared; only
//  slots below the count are ever read.
//
module sorted_message_queue
  import smq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic             clk,
  input  logic             rst,
  // input transactions
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             cmd,
  input  logic [KEY_W-1:0] start_date,
  input  logic [KEY_W-1:0] end_date,
  input  logic [TAG_W-1:0] message_tag,
  // result transactions
  output logic             out_valid,
  input  logic             out_stall,
  output logic [STS_W-1:0] status,
  output logic [KEY_W-1:0] popped_start_date,
  output logic [KEY_W-1:0] popped_end_date,
  output logic [TAG_W-1:0] popped_tag,
  output logic [OCC_W-1:0] occupancy
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for a transaction
  localparam logic [2:0] S_POP   = 3'd1;  // head entry arriving from memory
  localparam logic [2:0] S_INS   = 3'd2;  // scanning down from the tail, shifting up
  localparam logic [2:0] S_PLACE = 3'd3;  // new entry goes to the head slot
  localparam logic [2:0] S_RES   = 3'd4;  // result waits for the output register

  // logical slot to physical address in the circular buffer
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [AW-1:0] l);
    logic [AW:0] s;
    s = {1'b0, h} + {1'b0, l};
    if (s >= (AW + 1)'(CAPACITY)) begin
      s = s - (AW + 1)'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  // control and data registers
  logic [2:0]    state, state_next;
  logic [AW-1:0] head, head_next;      // physical address of the queue head
  logic [CW-1:0] count, count_next;    // entries held
  logic [AW-1:0] idx, idx_next;        // logical slot under the scan
  entry_t        cur, cur_next;        // entry being inserted
  result_t       res, res_next;        // result parked while output is busy
  result_t       out_q;

  // storage
  entry_t        mem [CAPACITY];
  entry_t        rd_data;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  entry_t        wr_data;

  // completion and output load
  logic          in_acc;
  logic          fin_valid;
  result_t       fin;
  logic          out_free;
  logic          out_load;
  result_t       load_data;
  logic [CW-1:0] cnt_m1;
  entry_t        new_item;

  assign in_stall = rst | (state != S_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign out_free = ~out_valid | ~out_stall;
  assign cnt_m1   = count - 1'b1;

  assign new_item.key  = start_date;
  assign new_item.ends = end_date;
  assign new_item.tag  = message_tag;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    state_next = state;
    head_next  = head;
    count_next = count;
    idx_next   = idx;
    cur_next   = cur;
    res_next   = res;
    rd_en      = 1'b0;
    rd_addr    = head;
    wr_en      = 1'b0;
    wr_addr    = head;
    wr_data    = cur;
    fin_valid  = 1'b0;
    fin        = '0;
    out_load   = 1'b0;
    load_data  = res;

    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          cur_next = new_item;
          if (cmd == CMD_POP) begin
            if (count == '0) begin
              fin_valid  = 1'b1;
              fin.status = ST_EMPTY;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = head;
              state_next = S_POP;
            end
          end else begin
            if (count == CAP_C) begin
              fin_valid  = 1'b1;
              fin.status = ST_FULL;
            end else if (count == '0) begin
              // first entry goes straight to the head slot
              wr_en      = 1'b1;
              wr_addr    = head;
              wr_data    = new_item;
              count_next = count + 1'b1;
              fin_valid  = 1'b1;
              fin.status = ST_DONE;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = phys(head, cnt_m1[AW-1:0]);
              idx_next   = cnt_m1[AW-1:0];
              state_next = S_INS;
            end
          end
        end
      end
      S_POP: begin
        head_next      = phys(head, AW'(1));
        count_next     = count - 1'b1;
        fin_valid      = 1'b1;
        fin.status     = ST_DONE;
        fin.start_date = rd_data.key;
        fin.end_date   = rd_data.ends;
        fin.tag        = rd_data.tag;
      end
      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = phys(head, idx + 1'b1);
        if (key_less(rd_data.key, cur.key)) begin
          // stored key is smaller: new entry lands just above it
          wr_data    = cur;
          count_next = count + 1'b1;
          fin_valid  = 1'b1;
          fin.status = ST_DONE;
        end else begin
          // equal or larger key moves up one slot
          wr_data = rd_data;
          if (idx == '0) begin
            state_next = S_PLACE;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = phys(head, idx - 1'b1);
            idx_next = idx - 1'b1;
          end
        end
      end
      S_PLACE: begin
        wr_en      = 1'b1;
        wr_addr    = head;
        wr_data    = cur;
        count_next = count + 1'b1;
        fin_valid  = 1'b1;
        fin.status = ST_DONE;
      end
      S_RES: begin
        if (out_free) begin
          out_load   = 1'b1;
          load_data  = res;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    fin.occupancy = OCC_W'(count_next);

    // finished result: straight to the output when free, else park it
    if (fin_valid) begin
      if (out_free) begin
        out_load   = 1'b1;
        load_data  = fin;
        state_next = S_IDLE;
      end else begin
        res_next   = fin;
        state_next = S_RES;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      idx   <= idx_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
    cur <= cur_next;
    res <= res_next;
    if (out_load) begin
      out_q <= load_data;
    end
  end

  assign status            = out_q.status;
  assign popped_start_date = out_q.start_date;
  assign popped_end_date   = out_q.end_date;
  assign popped_tag        = out_q.tag;
  assign occupancy         = out_q.occupancy;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_C)
    else $error("entry count above capacity");

  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    state == S_POP |=> count == $past(count) - 1'b1)
    else $error("pop did not drop the count by one");

  a_rw_apart: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en) |-> rd_addr != wr_addr)
    else $error("read and write hit the same slot during a shift");

  a_no_wr_idle_states: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_IDLE || state == S_INS || state == S_PLACE))
    else $error("memory write outside insert handling");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (out_load && load_data.status == ST_EMPTY) |-> count == '0)
    else $error("empty status with entries held");

endmodule
